// File: sv/f2sd_pkg.sv
`default_nettype none
package f2sd_pkg;

  localparam int unsigned WordW       = 32;
  localparam int unsigned ScaleW      = 5;
  localparam int unsigned SigDigitsDef = 7;
  localparam int unsigned MaxScale    = 28;

  // Exact fixed-point split of a binary32 magnitude.
  localparam int unsigned IntW   = 96;
  localparam int unsigned FracW  = 149;
  localparam int unsigned FullW  = IntW + FracW;
  localparam int unsigned BcdDig = 29;
  localparam int unsigned BcdW   = 4 * BcdDig;

  localparam int unsigned PosW   = 7;
  localparam int signed   TopPos  = 28;
  localparam int signed   TinyPos = -28;

  localparam logic [7:0] ExpSpecial = 8'hFF;
  localparam logic [7:0] ExpTooBig  = 8'd223;

endpackage
`default_nettype wire

// File: sv/float_to_scaled_decimal_top.sv
`default_nettype none
// Channel  Handshake              Payload
// in       in_valid_i/in_ready_o  float_bits_i
// out      out_valid_o/out_ready_i word_low_o word_mid_o word_high_o negative_o scale_o error_o
//
// One item at a time: a binary-to-BCD shift of the 96-bit integer part, then one
// decimal digit per cycle until the rounding digit, then trailing-zero and scale
// steps and a multiply-by-ten pass per digit. Zero, infinite, NaN and too-large
// inputs go straight to the output step; tiny ones leave the stream flagged as errors.
// Reset is asynchronous and clears the sequencer and the output valid flag.
// The next item is taken while a finished result waits in the output register.
module float_to_scaled_decimal_top #(
  parameter int unsigned SIG_DIGITS = f2sd_pkg::SigDigitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [f2sd_pkg::WordW-1:0]    float_bits_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [f2sd_pkg::WordW-1:0]         word_low_o,
  output logic [f2sd_pkg::WordW-1:0]         word_mid_o,
  output logic [f2sd_pkg::WordW-1:0]         word_high_o,
  output logic                               negative_o,
  output logic [f2sd_pkg::ScaleW-1:0]        scale_o,
  output logic                               error_o
);
  import f2sd_pkg::*;

  localparam int unsigned NDig = SIG_DIGITS + 1;
  localparam int unsigned NbW  = 4 * NDig;
  localparam int unsigned DcW  = $clog2(SIG_DIGITS + 1);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StDabble = 4'd1;
  localparam logic [3:0] StStream = 4'd2;
  localparam logic [3:0] StStrip  = 4'd3;
  localparam logic [3:0] StCap    = 4'd4;
  localparam logic [3:0] StHorner = 4'd5;
  localparam logic [3:0] StDone   = 4'd6;

  logic [3:0]              state_q, state_d;
  logic                    neg_q, neg_d;
  logic                    err_q, err_d;
  logic [IntW-1:0]         ibin_q, ibin_d;
  logic [FracW-1:0]        frac_q, frac_d;
  logic [BcdW-1:0]         bcd_q, bcd_d;
  logic [6:0]              cnt_q, cnt_d;
  logic signed [PosW-1:0]  pos_q, pos_d;
  logic                    started_q, started_d;
  logic [DcW-1:0]          dcnt_q, dcnt_d;
  logic [NbW-1:0]          nb_q, nb_d;
  logic [5:0]              scale_q, scale_d;
  logic [4:0]              mulcnt_q, mulcnt_d;
  logic [3:0]              gd_q, gd_d;
  logic                    st_q, st_d;
  logic [IntW-1:0]         acc_q, acc_d;

  logic                    out_valid_q, out_valid_d;
  logic [WordW-1:0]        wlo_q, wlo_d, wmi_q, wmi_d, whi_q, whi_d;
  logic                    oneg_q, oneg_d, oerr_q, oerr_d;
  logic [ScaleW-1:0]       oscale_q, oscale_d;

  logic [7:0]              expo;
  logic [23:0]             mant;
  logic [7:0]              shamt;
  logic [FullW-1:0]        xfull;
  logic [BcdW-1:0]         adj;
  logic [FracW+3:0]        prod;
  logic                    in_int;
  logic [3:0]              dig;
  logic                    rest;
  logic                    round_up;
  logic [NbW-1:0]          nb_inc;
  logic signed [PosW-1:0]  kval;
  logic [3:0]              hdig;
  logic [IntW+3:0]         acc10;

  function automatic logic [NbW-1:0] bcd_inc(input logic [NbW-1:0] v);
    logic [NbW-1:0] r;
    logic           c;
    logic [3:0]     dg;
    r = v;
    c = 1'b1;
    for (int i = 0; i < NDig; i++) begin
      dg = v[4*i +: 4];
      if (c) begin
        if (dg == 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = dg + 4'd1;
          c = 1'b0;
        end
      end
    end
    return r;
  endfunction

  assign expo  = float_bits_i[30:23];
  assign mant  = (expo == 8'd0) ? {1'b0, float_bits_i[22:0]} : {1'b1, float_bits_i[22:0]};
  assign shamt = (expo == 8'd0) ? 8'd0 : expo - 8'd1;
  // Bits above the binary point land in the top IntW bits.
  assign xfull = FullW'(mant) << shamt;

  always_comb begin
    for (int i = 0; i < BcdDig; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
  end

  assign prod   = {1'b0, frac_q, 3'b000} + {3'b000, frac_q, 1'b0};
  assign in_int = ~pos_q[PosW-1];
  assign dig    = in_int ? bcd_q[BcdW-1 -: 4] : prod[FracW+3 -: 4];
  assign rest   = in_int ? ((bcd_q[BcdW-5:0] != '0) || (frac_q != '0))
                         : (prod[FracW-1:0] != '0);
  assign nb_inc = bcd_inc(nb_q);
  assign kval   = pos_q + PosW'(1);
  assign hdig   = (cnt_q != 7'd0) ? nb_q[NbW-1 -: 4] : 4'd0;
  assign acc10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {{IntW{1'b0}}, hdig};

  always_comb begin
    round_up = 1'b0;
    if (state_q == StCap) begin
      round_up = (gd_q > 4'd5) || ((gd_q == 4'd5) && (st_q || nb_q[0]));
    end else begin
      round_up = (dig > 4'd5) || ((dig == 4'd5) && (rest || nb_q[0]));
    end
  end

  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    err_d       = err_q;
    ibin_d      = ibin_q;
    frac_d      = frac_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    started_d   = started_q;
    dcnt_d      = dcnt_q;
    nb_d        = nb_q;
    scale_d     = scale_q;
    mulcnt_d    = mulcnt_q;
    gd_d        = gd_q;
    st_d        = st_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    wlo_d       = wlo_q;
    wmi_d       = wmi_q;
    whi_d       = whi_q;
    oneg_d      = oneg_q;
    oerr_d      = oerr_q;
    oscale_d    = oscale_q;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          neg_d   = float_bits_i[31];
          err_d   = 1'b0;
          acc_d   = '0;
          scale_d = '0;
          if ((expo == ExpSpecial) || (expo >= ExpTooBig)) begin
            err_d   = 1'b1;
            state_d = StDone;
          end else if (mant == 24'd0) begin
            state_d = StDone;
          end else begin
            ibin_d  = xfull[FullW-1 -: IntW];
            frac_d  = xfull[FracW-1:0];
            bcd_d   = '0;
            cnt_d   = 7'(IntW);
            state_d = StDabble;
          end
        end
      end
      StDabble: begin
        bcd_d  = {adj[BcdW-2:0], ibin_q[IntW-1]};
        ibin_d = ibin_q << 1;
        cnt_d  = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          pos_d     = PosW'(TopPos);
          started_d = 1'b0;
          dcnt_d    = '0;
          state_d   = StStream;
        end
      end
      StStream: begin
        pos_d = pos_q - PosW'(1);
        if (in_int) begin
          bcd_d = bcd_q << 4;
        end else begin
          frac_d = prod[FracW-1:0];
        end
        if (started_q && (dcnt_q == DcW'(SIG_DIGITS))) begin
          // This digit is the rounding digit; the rest feeds the sticky term.
          nb_d     = round_up ? nb_inc : nb_q;
          mulcnt_d = '0;
          if (!kval[PosW-1]) begin
            mulcnt_d = kval[4:0];
            scale_d  = '0;
            acc_d    = '0;
            cnt_d    = 7'(NDig);
            state_d  = StHorner;
          end else begin
            scale_d = 6'(-kval);
            state_d = StStrip;
          end
        end else if (started_q) begin
          nb_d   = {nb_q[NbW-5:0], dig};
          dcnt_d = dcnt_q + DcW'(1);
        end else if (dig != 4'd0) begin
          started_d = 1'b1;
          nb_d      = NbW'(dig);
          dcnt_d    = DcW'(1);
        end else if (pos_q == PosW'(TinyPos)) begin
          err_d   = 1'b1;
          acc_d   = '0;
          state_d = StDone;
        end
      end
      StStrip: begin
        if ((scale_q != 6'd0) && (nb_q[3:0] == 4'd0) && (nb_q != '0)) begin
          nb_d    = nb_q >> 4;
          scale_d = scale_q - 6'd1;
        end else if (scale_q > 6'(MaxScale)) begin
          cnt_d   = 7'(scale_q - 6'(MaxScale));
          gd_d    = 4'd0;
          st_d    = 1'b0;
          state_d = StCap;
        end else begin
          acc_d   = '0;
          cnt_d   = 7'(NDig);
          state_d = StHorner;
        end
      end
      StCap: begin
        if (cnt_q != 7'd0) begin
          st_d  = st_q | (gd_q != 4'd0);
          gd_d  = nb_q[3:0];
          nb_d  = nb_q >> 4;
          cnt_d = cnt_q - 7'd1;
        end else begin
          nb_d    = round_up ? nb_inc : nb_q;
          scale_d = 6'(MaxScale);
          state_d = StStrip;
        end
      end
      StHorner: begin
        if (cnt_q != 7'd0) begin
          acc_d = acc10[IntW-1:0];
          err_d = err_q | (acc10[IntW+3:IntW] != 4'd0);
          nb_d  = nb_q << 4;
          cnt_d = cnt_q - 7'd1;
        end else if (mulcnt_q != 5'd0) begin
          acc_d    = acc10[IntW-1:0];
          err_d    = err_q | (acc10[IntW+3:IntW] != 4'd0);
          mulcnt_d = mulcnt_q - 5'd1;
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          oerr_d      = err_q;
          if (err_q || (acc_q == '0)) begin
            wlo_d    = '0;
            wmi_d    = '0;
            whi_d    = '0;
            oneg_d   = 1'b0;
            oscale_d = '0;
          end else begin
            wlo_d    = acc_q[31:0];
            wmi_d    = acc_q[63:32];
            whi_d    = acc_q[95:64];
            oneg_d   = neg_q;
            oscale_d = scale_q[ScaleW-1:0];
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      started_q   <= 1'b0;
      dcnt_q      <= '0;
      cnt_q       <= '0;
      mulcnt_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      started_q   <= started_d;
      dcnt_q      <= dcnt_d;
      cnt_q       <= cnt_d;
      mulcnt_q    <= mulcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q    <= neg_d;
    err_q    <= err_d;
    ibin_q   <= ibin_d;
    frac_q   <= frac_d;
    bcd_q    <= bcd_d;
    pos_q    <= pos_d;
    nb_q     <= nb_d;
    scale_q  <= scale_d;
    gd_q     <= gd_d;
    st_q     <= st_d;
    acc_q    <= acc_d;
    wlo_q    <= wlo_d;
    wmi_q    <= wmi_d;
    whi_q    <= whi_d;
    oneg_q   <= oneg_d;
    oerr_q   <= oerr_d;
    oscale_q <= oscale_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign word_low_o  = wlo_q;
  assign word_mid_o  = wmi_q;
  assign word_high_o = whi_q;
  assign negative_o  = oneg_q;
  assign scale_o     = oscale_q;
  assign error_o     = oerr_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> (word_low_o == '0) && (word_mid_o == '0) &&
      (word_high_o == '0) && !negative_o && (scale_o == '0))
    else $error("error item carries nonzero fields");

  a_scale_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> scale_o <= ScaleW'(MaxScale))
    else $error("scale above cap");

  a_neg_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (negative_o || (scale_o != '0)) |->
      ((word_low_o != '0) || (word_mid_o != '0) || (word_high_o != '0)))
    else $error("sign or scale on a zero coefficient");

  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcnt_q <= DcW'(SIG_DIGITS))
    else $error("too many digits collected");

endmodule
`default_nettype wire
